// ----- hw/rtl/mecanum_odometry_integrator_assert.svh -----
// Assertion macros for the mecanum odometry integrator.
`ifndef MECANUM_ODOMETRY_INTEGRATOR_ASSERT_SVH
`define MECANUM_ODOMETRY_INTEGRATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MECODO_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define MECODO_CHECK_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
`define MECODO_CHECK_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define MECODO_CHECK(label, cond, msg)
`define MECODO_CHECK_IMP(label, pre, post, msg)
`define MECODO_CHECK_NXT(label, pre, post, msg)
`endif
`endif

// ----- hw/rtl/mecodo_pkg.sv -----
// Shared types, constants and tables of the mecanum odometry integrator.
package mecodo_pkg;

  localparam int CountW = 32;
  localparam int PoseW = 32;
  localparam int HeadW = 31;
  localparam int AngW = 32;
  localparam int RotW = 34;
  localparam int MulAW = 32;
  localparam int MulBW = 32;
  localparam int ProdW = MulAW + MulBW;
  localparam int CfgW = 32;
  localparam int PaddrW = 3;
  localparam int CordicStepsDef = 24;

  localparam logic [CfgW-1:0] MptReset = 32'd0;
  localparam logic [CfgW-1:0] IrrReset = 32'd16777216;
  localparam logic [MulBW-1:0] InvGainQ32 = 32'd2608131496;
  localparam logic signed [AngW-1:0] PiQ28 = 32'sd843314857;
  localparam logic signed [AngW-1:0] HalfPiQ28 = 32'sd421657428;
  localparam logic signed [AngW-1:0] TwoPiQ28 = 32'sd1686629713;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  typedef enum logic {
    REG_MPT = 1'b0,
    REG_IRR = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_WHEEL,
    ST_MUL_TURN,
    ST_MUL_FWD,
    ST_MUL_RGT,
    ST_ROT_START,
    ST_ROT,
    ST_UPDATE,
    ST_FINISH
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // Arctangent of 2^-i in Q3.28 radians.
  function automatic logic [AngW-1:0] atan_q28(input logic [4:0] idx);
    logic [AngW-1:0] v;
    case (idx)
      5'd0:  v = 32'd210828714;
      5'd1:  v = 32'd124459457;
      5'd2:  v = 32'd65760959;
      5'd3:  v = 32'd33381290;
      5'd4:  v = 32'd16755422;
      5'd5:  v = 32'd8385879;
      5'd6:  v = 32'd4193963;
      5'd7:  v = 32'd2097109;
      5'd8:  v = 32'd1048571;
      5'd9:  v = 32'd524287;
      5'd10: v = 32'd262144;
      5'd11: v = 32'd131072;
      5'd12: v = 32'd65536;
      5'd13: v = 32'd32768;
      5'd14: v = 32'd16384;
      5'd15: v = 32'd8192;
      5'd16: v = 32'd4096;
      5'd17: v = 32'd2048;
      5'd18: v = 32'd1024;
      5'd19: v = 32'd512;
      5'd20: v = 32'd256;
      5'd21: v = 32'd128;
      5'd22: v = 32'd64;
      5'd23: v = 32'd32;
      5'd24: v = 32'd16;
      5'd25: v = 32'd8;
      5'd26: v = 32'd4;
      5'd27: v = 32'd2;
      5'd28: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/mecodo_if.sv -----
// Input and result channel interfaces of the mecanum odometry integrator.
interface mecodo_in_if import mecodo_pkg::*; ();
  logic valid;
  logic ready;
  logic operation;
  logic signed [CountW-1:0] front_left_count;
  logic signed [CountW-1:0] front_right_count;
  logic signed [CountW-1:0] rear_left_count;
  logic signed [CountW-1:0] rear_right_count;

  modport source (output valid, operation, front_left_count, front_right_count,
                  rear_left_count, rear_right_count, input ready);
  modport sink (input valid, operation, front_left_count, front_right_count,
                rear_left_count, rear_right_count, output ready);
endinterface

interface mecodo_out_if import mecodo_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [PoseW-1:0] position_x;
  logic signed [PoseW-1:0] position_y;
  logic signed [HeadW-1:0] heading;
  logic primed;

  modport source (output valid, position_x, position_y, heading, primed, input ready);
  modport sink (input valid, position_x, position_y, heading, primed, output ready);
endinterface

// ----- hw/rtl/mecanum_odometry_integrator.sv -----
// Mecanum wheel odometry integrator: encoder counts in, fixed-point pose out.
// One beat in gives one beat out. A clear or a priming beat skips the products
// and the rotation and goes straight to the output stage. An update runs a
// single bit-serial multiplier through seven products in turn (four wheel
// scalings, the turn angle and the two gain corrections), then the CORDIC unit
// rotates one step per cycle. Input is taken only while the sequencer is idle;
// a finished pose waits in the output register while the next beat is taken.
// Position is Q16.16 metres, heading Q2.28 radians kept within plus or minus pi.
`include "mecanum_odometry_integrator_assert.svh"
module mecanum_odometry_integrator import mecodo_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic              clk,
  input  logic              rst_n,
  mecodo_in_if.sink         in_ch,
  mecodo_out_if.source      out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [CfgW-1:0]   pwdata,
  output logic [CfgW-1:0]   prdata,
  output logic              pready
);

  seq_state_t state_r, state_nxt;

  logic [CfgW-1:0] mpt_r, mpt_nxt, irr_r, irr_nxt;
  logic signed [CountW-1:0] prev_r [4];
  logic signed [CountW-1:0] prev_nxt [4];
  logic primed_r, primed_nxt;
  logic signed [PoseW-1:0] pose_x_r, pose_x_nxt, pose_y_r, pose_y_nxt;
  logic signed [HeadW-1:0] heading_r, heading_nxt;
  logic out_valid_r, out_valid_nxt;
  logic issued_r, issued_nxt;
  logic [1:0] widx_r, widx_nxt;

  logic signed [CountW-1:0] delta_r [4];
  logic signed [CountW-1:0] delta_nxt [4];
  logic signed [PoseW-1:0] d_r [4];
  logic signed [PoseW-1:0] d_nxt [4];
  logic signed [AngW-1:0] dth_r, dth_nxt;
  logic signed [PoseW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [PoseW-1:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic signed [HeadW-1:0] oh_r, oh_nxt;
  logic oprim_r, oprim_nxt;

  logic in_accept, out_accept, cfg_write, in_clear, slot_free, in_mul_state;
  logic signed [CountW-1:0] in_counts [4];

  logic mul_start;
  logic signed [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  unit_stat_t mul_stat;
  logic signed [ProdW-1:0] prod;

  logic rot_start;
  logic signed [RotW-1:0] rot_x_in, rot_y_in, rot_x_out, rot_y_out;
  logic signed [AngW-1:0] rot_z_in, z_mid;
  unit_stat_t rot_stat;

  logic signed [33:0] sum_fwd, sum_rgt, sum_turn;
  logic signed [PoseW-1:0] fwd, rgt, turn, wheel_d;
  logic signed [49:0] dth_wide;
  logic signed [AngW-1:0] dth_sat, h_sum;

  assign in_counts[0] = in_ch.front_left_count;
  assign in_counts[1] = in_ch.front_right_count;
  assign in_counts[2] = in_ch.rear_left_count;
  assign in_counts[3] = in_ch.rear_right_count;

  assign in_accept = in_ch.valid && in_ch.ready;
  assign out_accept = out_ch.valid && out_ch.ready;
  assign in_clear = op_t'(in_ch.operation) == OP_CLEAR;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign in_mul_state = (state_r == ST_MUL_WHEEL) || (state_r == ST_MUL_TURN) ||
                        (state_r == ST_MUL_FWD) || (state_r == ST_MUL_RGT);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = (in_clear || !primed_r) ? ST_FINISH : ST_MUL_WHEEL;
        end
      end
      ST_MUL_WHEEL: if (mul_stat.done && widx_r == 2'd3) state_nxt = ST_MUL_TURN;
      ST_MUL_TURN:  if (mul_stat.done) state_nxt = ST_MUL_FWD;
      ST_MUL_FWD:   if (mul_stat.done) state_nxt = ST_MUL_RGT;
      ST_MUL_RGT:   if (mul_stat.done) state_nxt = ST_ROT_START;
      ST_ROT_START: state_nxt = ST_ROT;
      ST_ROT:       if (rot_stat.done) state_nxt = ST_UPDATE;
      ST_UPDATE:    state_nxt = ST_FINISH;
      ST_FINISH:    if (slot_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Combine the scaled wheel travels; derive wheel travel and turn angle from the product
  always_comb begin
    sum_fwd = 34'(d_r[0]) + 34'(d_r[1]) + 34'(d_r[2]) + 34'(d_r[3]);
    sum_rgt = 34'(d_r[0]) - 34'(d_r[1]) - 34'(d_r[2]) + 34'(d_r[3]);
    sum_turn = 34'(d_r[0]) - 34'(d_r[1]) + 34'(d_r[2]) - 34'(d_r[3]);
    fwd = sum_fwd[33:2];
    rgt = sum_rgt[33:2];
    if (sum_turn > 34'sh0_7FFF_FFFF) begin
      turn = 32'sh7FFF_FFFF;
    end else if (sum_turn < -34'sh0_8000_0000) begin
      turn = 32'sh8000_0000;
    end else begin
      turn = sum_turn[31:0];
    end
    // wheel travel: product floored by 2^16, saturated to 32 bits
    if (prod[63:47] == '0 || prod[63:47] == '1) begin
      wheel_d = prod[47:16];
    end else begin
      wheel_d = prod[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    dth_wide = prod[63:14];
    if (dth_wide > PiQ28) begin
      dth_sat = PiQ28;
    end else if (dth_wide < -PiQ28) begin
      dth_sat = -PiQ28;
    end else begin
      dth_sat = dth_wide[31:0];
    end
  end

  // Multiplier operand selection and CORDIC set-up
  always_comb begin
    mul_start = in_mul_state && !issued_r;
    case (state_r)
      ST_MUL_TURN: begin
        mul_a = turn;
        mul_b = irr_r;
      end
      ST_MUL_FWD: begin
        mul_a = fwd;
        mul_b = InvGainQ32;
      end
      ST_MUL_RGT: begin
        mul_a = rgt;
        mul_b = InvGainQ32;
      end
      default: begin
        mul_a = delta_r[widx_r];
        mul_b = mpt_r;
      end
    endcase
    z_mid = AngW'(heading_r) + (dth_r >>> 1);
    rot_start = state_r == ST_ROT_START;
    rot_x_in = RotW'(x_r);
    rot_y_in = RotW'(y_r);
    rot_z_in = z_mid;
    // fold into the right half plane
    if (z_mid > HalfPiQ28) begin
      rot_z_in = z_mid - PiQ28;
      rot_x_in = -RotW'(x_r);
      rot_y_in = -RotW'(y_r);
    end else if (z_mid < -HalfPiQ28) begin
      rot_z_in = z_mid + PiQ28;
      rot_x_in = -RotW'(x_r);
      rot_y_in = -RotW'(y_r);
    end
    h_sum = AngW'(heading_r) + dth_r;
  end

  // Register next values
  always_comb begin
    mpt_nxt = mpt_r;
    irr_nxt = irr_r;
    prev_nxt = prev_r;
    primed_nxt = primed_r;
    pose_x_nxt = pose_x_r;
    pose_y_nxt = pose_y_r;
    heading_nxt = heading_r;
    out_valid_nxt = out_valid_r;
    issued_nxt = issued_r;
    widx_nxt = widx_r;
    delta_nxt = delta_r;
    d_nxt = d_r;
    dth_nxt = dth_r;
    x_nxt = x_r;
    y_nxt = y_r;
    ox_nxt = ox_r;
    oy_nxt = oy_r;
    oh_nxt = oh_r;
    oprim_nxt = oprim_r;

    if (cfg_write) begin
      case (reg_idx_t'(paddr[2]))
        REG_MPT: mpt_nxt = pwdata;
        REG_IRR: irr_nxt = pwdata;
        default: mpt_nxt = mpt_r;
      endcase
    end

    if (in_accept) begin
      widx_nxt = '0;
      if (in_clear) begin
        for (int i = 0; i < 4; i++) prev_nxt[i] = '0;
        primed_nxt = 1'b0;
        pose_x_nxt = '0;
        pose_y_nxt = '0;
        heading_nxt = '0;
      end else begin
        for (int i = 0; i < 4; i++) begin
          delta_nxt[i] = in_counts[i] - prev_r[i];
          prev_nxt[i] = in_counts[i];
        end
        primed_nxt = 1'b1;
      end
    end

    if (mul_start) begin
      issued_nxt = 1'b1;
    end else if (mul_stat.done) begin
      issued_nxt = 1'b0;
    end

    if (mul_stat.done) begin
      case (state_r)
        ST_MUL_WHEEL: begin
          d_nxt[widx_r] = wheel_d;
          widx_nxt = widx_r + 1'b1;
        end
        ST_MUL_TURN: dth_nxt = dth_sat;
        ST_MUL_FWD:  x_nxt = prod[63:32];
        ST_MUL_RGT:  y_nxt = prod[63:32];
        default:     dth_nxt = dth_r;
      endcase
    end

    if (state_r == ST_UPDATE) begin
      pose_x_nxt = pose_x_r + rot_x_out[PoseW-1:0];
      pose_y_nxt = pose_y_r + rot_y_out[PoseW-1:0];
      if (h_sum > PiQ28) begin
        heading_nxt = HeadW'(h_sum - TwoPiQ28);
      end else if (h_sum < -PiQ28) begin
        heading_nxt = HeadW'(h_sum + TwoPiQ28);
      end else begin
        heading_nxt = HeadW'(h_sum);
      end
    end

    if (out_accept) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == ST_FINISH && slot_free) begin
      out_valid_nxt = 1'b1;
      ox_nxt = pose_x_r;
      oy_nxt = pose_y_r;
      oh_nxt = heading_r;
      oprim_nxt = primed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mpt_r <= MptReset;
      irr_r <= IrrReset;
      for (int i = 0; i < 4; i++) prev_r[i] <= '0;
      primed_r <= 1'b0;
      pose_x_r <= '0;
      pose_y_r <= '0;
      heading_r <= '0;
      out_valid_r <= 1'b0;
      issued_r <= 1'b0;
      widx_r <= '0;
    end else begin
      state_r <= state_nxt;
      mpt_r <= mpt_nxt;
      irr_r <= irr_nxt;
      prev_r <= prev_nxt;
      primed_r <= primed_nxt;
      pose_x_r <= pose_x_nxt;
      pose_y_r <= pose_y_nxt;
      heading_r <= heading_nxt;
      out_valid_r <= out_valid_nxt;
      issued_r <= issued_nxt;
      widx_r <= widx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    delta_r <= delta_nxt;
    d_r <= d_nxt;
    dth_r <= dth_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    ox_r <= ox_nxt;
    oy_r <= oy_nxt;
    oh_r <= oh_nxt;
    oprim_r <= oprim_nxt;
  end

  mecodo_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (mul_a),
    .mplier  (mul_b),
    .stat    (mul_stat),
    .product (prod)
  );

  mecodo_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rot_start),
    .x_in  (rot_x_in),
    .y_in  (rot_y_in),
    .z_in  (rot_z_in),
    .stat  (rot_stat),
    .x_out (rot_x_out),
    .y_out (rot_y_out)
  );

  assign in_ch.ready = state_r == ST_IDLE;
  assign out_ch.valid = out_valid_r;
  assign out_ch.position_x = ox_r;
  assign out_ch.position_y = oy_r;
  assign out_ch.heading = oh_r;
  // hold the primed flag with the pose it belongs to
  assign out_ch.primed = oprim_r;
  assign pready = 1'b1;
  assign prdata = (reg_idx_t'(paddr[2]) == REG_IRR) ? irr_r : mpt_r;

  `MECODO_CHECK(a_heading_range, (heading_r <= PiQ28) && (heading_r >= -PiQ28), "heading out of range")
  `MECODO_CHECK_IMP(a_mul_start_free, mul_start, !mul_stat.busy, "multiplier restarted while busy")
  `MECODO_CHECK_NXT(a_clear_unprimes, in_accept && in_clear, !primed_r, "clear left primed set")
  `MECODO_CHECK_IMP(a_rot_done_state, rot_stat.done, state_r == ST_ROT, "stray rotation done")

endmodule

// ----- hw/rtl/mecodo_mul.sv -----
// Bit-serial signed by unsigned shift-add multiplier, one multiplier bit per cycle.
module mecodo_mul import mecodo_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [MulAW-1:0] mcand,
  input  logic [MulBW-1:0]        mplier,
  output unit_stat_t              stat,
  output logic signed [ProdW-1:0] product
);

  localparam int CntW = $clog2(MulBW);

  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic [MulAW:0] hi_r, hi_nxt;
  logic [MulBW-1:0] lo_r, lo_nxt;
  logic [MulAW-1:0] a_r, a_nxt;
  logic [MulAW+1:0] sum;
  logic [MulAW+MulBW:0] full;

  always_comb begin
    sum = {hi_r[MulAW], hi_r} + (lo_r[0] ? {{2{a_r[MulAW-1]}}, a_r} : '0);
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    a_nxt = a_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = '0;
      hi_nxt = '0;
      lo_nxt = mplier;
      a_nxt = mcand;
    end else if (busy_r) begin
      // add the partial product, then shift the pair right by one bit
      hi_nxt = sum[MulAW+1:1];
      lo_nxt = {sum[0], lo_r[MulBW-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(MulBW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    a_r <= a_nxt;
  end

  assign full = {hi_r, lo_r};
  assign product = signed'(full[ProdW-1:0]);
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ----- hw/rtl/mecodo_cordic.sv -----
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
module mecodo_cordic import mecodo_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [RotW-1:0] x_in,
  input  logic signed [RotW-1:0] y_in,
  input  logic signed [AngW-1:0] z_in,
  output unit_stat_t             stat,
  output logic signed [RotW-1:0] x_out,
  output logic signed [RotW-1:0] y_out
);

  localparam int SW = $clog2(CORDIC_STEPS);

  logic [SW-1:0] step_r, step_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic signed [RotW-1:0] x_r, x_nxt, y_r, y_nxt, xs, ys;
  logic signed [AngW-1:0] z_r, z_nxt, at;

  always_comb begin
    xs = x_r >>> step_r;
    ys = y_r >>> step_r;
    at = signed'(atan_q28(5'(step_r)));
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      x_nxt = x_in;
      y_nxt = y_in;
      z_nxt = z_in;
    end else if (busy_r) begin
      // rotate towards zero residual angle
      if (!z_r[AngW-1]) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + at;
      end
      step_nxt = step_r + 1'b1;
      if (step_r == SW'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign x_out = x_r;
  assign y_out = y_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
